FILE: rtl/faded_tone_burst_generator_assert.svh
// Assertion macros shared by the faded tone burst generator RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef FADED_TONE_BURST_GENERATOR_ASSERT_SVH
`define FADED_TONE_BURST_GENERATOR_ASSERT_SVH

// The property must hold at every clock edge outside of reset.
`define FTBG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside of reset.
`define FTBG_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/ftbg_pkg.sv
// Package for the faded tone burst generator: widths, register indexes and constants.
// Used by the channel interfaces and the top level; depends on nothing.
package ftbg_pkg;

    localparam int unsigned DEF_SINE_TABLE_DEPTH = 1024;
    localparam int unsigned DEF_TAIL_SAMPLES     = 1536;

    localparam int unsigned FREQ_W      = 16;
    localparam int unsigned DUR_W       = 16;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned IDX_W       = 20;
    localparam int unsigned FADE_W      = 7;
    localparam int unsigned TAIL_W      = 11;
    localparam int unsigned SINE_W      = 15;
    localparam int unsigned PHASE_W     = 32;

    localparam int unsigned MAG_GAIN_W = SINE_W + GAIN_W;
    localparam int unsigned ENV_AMP_W  = 20;
    localparam int unsigned PROD_W     = MAG_GAIN_W + ENV_AMP_W;
    localparam int unsigned MUL_SHIFT  = 27;
    localparam int unsigned STEP_PROD_W = 35;

    localparam int unsigned DIV_N_W    = 24;
    localparam int unsigned DIV_D_W    = 7;
    localparam int unsigned DIV_Q_W    = 16;
    localparam int unsigned DIV_BITS   = 4;
    localparam int unsigned DIV_ITER   = DIV_Q_W / DIV_BITS;
    localparam int unsigned DIV_CNT_W  = 2;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_ITER - 1);

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_GAIN_Q12 = cfg_index_t'(0);
    localparam cfg_index_t REG_SLEEPING = cfg_index_t'(1);

    typedef logic [1:0] run_mode_t;
    localparam run_mode_t MODE_IDLE = 2'd0;
    localparam run_mode_t MODE_TONE = 2'd1;
    localparam run_mode_t MODE_TAIL = 2'd2;

    localparam int unsigned GAIN_RESET = 4096;
    localparam int unsigned DEFAULT_HZ = 1000;
    localparam int unsigned DEFAULT_MS = 250;
    localparam int unsigned AMP_SCALE  = 12000;
    localparam int unsigned RAMP_MAX   = 80;
    localparam int unsigned SINE_MAX   = 32767;

    // The phase step hz * 2^32 / 16000 equals hz * 268435 + hz * 57 / 125.
    localparam int unsigned STEP_WHOLE = 268435;
    localparam int unsigned STEP_REM   = 57;
    localparam int unsigned STEP_DIV   = 125;

    localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam int unsigned TAYLOR_TERMS = 7;
    localparam logic [63:0] TAYLOR_DIV [1:7] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

endpackage

FILE: rtl/ftbg_if.sv
// Valid/ready channel interfaces of the faded tone burst generator.
// Depends on ftbg_pkg for the payload widths.
interface ftbg_cmd_if
    import ftbg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [FREQ_W-1:0] freq_hz;
    logic [DUR_W-1:0]  length_ms;

    modport source (output valid, output action, output freq_hz, output length_ms,
                    input ready);
    modport sink (input valid, input action, input freq_hz, input length_ms,
                  output ready);
endinterface

interface ftbg_pcm_if
    import ftbg_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       in_tail;
    logic                       last;

    modport source (output valid, output sample, output in_tail, output last,
                    input ready);
    modport sink (input valid, input sample, input in_tail, input last,
                  output ready);
endinterface

FILE: rtl/faded_tone_burst_generator.sv
// Top level of the faded tone burst generator: control, sine ROM, multipliers and divider.
// Depends on ftbg_pkg, the channel interfaces in ftbg_if.sv and the assertion macros.
//
// A start item sets up a burst of 16 samples per millisecond of a sine tone at 16 kHz sampling
// with a linear fade at both ends, and each tick item then yields one PCM sample, followed by a
// run of silent tail samples. The sine comes from a registered quarter-wave ROM, the sample goes
// through two registered multiply stages, and the fade division runs in a shared divider that
// retires four quotient bits per cycle. The input waits while a tone tick runs the address, ROM,
// multiply, divider and emit states (held in emit while the output register is full), a start
// the step and divider states, and a tail tick the emit state. No clearing pass follows reset.
`include "faded_tone_burst_generator_assert.svh"

module faded_tone_burst_generator
    import ftbg_pkg::*;
#(
    parameter int unsigned SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int unsigned TAIL_SAMPLES     = DEF_TAIL_SAMPLES
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    ftbg_cmd_if.sink               cmd,
    ftbg_pcm_if.source             pcm
);

    localparam int unsigned A_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int unsigned P_W = $clog2(4 * SINE_TABLE_DEPTH);
    localparam logic [P_W:0]   QUAD_SCALE = (P_W + 1)'(4 * SINE_TABLE_DEPTH);
    localparam logic [P_W-1:0] QUAD1 = P_W'(SINE_TABLE_DEPTH);
    localparam logic [P_W-1:0] QUAD2 = P_W'(2 * SINE_TABLE_DEPTH);
    localparam logic [P_W-1:0] QUAD3 = P_W'(3 * SINE_TABLE_DEPTH);
    localparam logic [A_W-1:0] POS_TOP = A_W'(SINE_TABLE_DEPTH);
    localparam logic [63:0] ANGLE_DEN = 64'(2 * SINE_TABLE_DEPTH);
    localparam logic [TAIL_W-1:0] TAIL_LOAD = TAIL_W'(TAIL_SAMPLES);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADDR     = 4'd1;
    localparam logic [3:0] S_ROM      = 4'd2;
    localparam logic [3:0] S_MUL1     = 4'd3;
    localparam logic [3:0] S_MUL2     = 4'd4;
    localparam logic [3:0] S_DIV_LOAD = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_FIN      = 4'd7;
    localparam logic [3:0] S_STEP     = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH + 1];

    // Entry k is sin(pi*k/(2*depth)) in Q15 from a truncated Taylor series in Q30.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] q;
        for (int k = 0; k <= int'(SINE_TABLE_DEPTH); k++) begin
            x    = (PI_Q30 * 64'(k)) / ANGLE_DEN;
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int j = 1; j <= int'(TAYLOR_TERMS); j++) begin
                term = (term * x2) >> 30;
                term = term / TAYLOR_DIV[j];
                if ((j & 1) != 0) begin
                    acc = acc - term;
                end
                else begin
                    acc = acc + term;
                end
            end
            q = (acc + 64'd16384) >> 15;
            if (q > 64'(SINE_MAX)) begin
                q = 64'(SINE_MAX);
            end
            tab[k] = q[SINE_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [3:0]             state_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic                   sleeping_reg;
    logic [PHASE_W-1:0]     phase_acc_reg;
    logic [PHASE_W-1:0]     phase_step_reg;
    logic [IDX_W-1:0]       sample_index_reg;
    logic [IDX_W-1:0]       frame_total_reg;
    logic [FADE_W-1:0]      fade_reg;
    logic [TAIL_W-1:0]      tail_count_reg;
    run_mode_t              mode_reg;
    logic                   op_start_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic                   out_valid_reg;

    logic [FREQ_W-1:0]      hz_reg;
    logic [P_W-1:0]         p_reg;
    logic                   neg_reg;
    logic [A_W-1:0]         pos_reg;
    logic [SINE_W-1:0]      rom_q_reg;
    logic [FADE_W-1:0]      env_reg;
    logic [FADE_W-1:0]      den_reg;
    logic [MAG_GAIN_W-1:0]  a_reg;
    logic [ENV_AMP_W-1:0]   b_reg;
    logic [PHASE_W-1:0]     step_hi_reg;
    logic [DIV_N_W-1:0]     div_n_reg;
    logic [DIV_D_W-1:0]     div_d_reg;
    logic                   div_sat_reg;
    logic [DIV_D_W-1:0]     rem_reg;
    logic [DIV_Q_W-1:0]     nlo_reg;
    logic [DIV_Q_W-1:0]     quo_reg;
    logic [SAMPLE_W-1:0]    res_sample_reg;
    logic                   res_in_tail_reg;
    logic                   res_last_reg;
    logic [SAMPLE_W-1:0]    out_sample_reg;
    logic                   out_in_tail_reg;
    logic                   out_last_reg;

    logic                   cmd_take;
    logic                   out_free;
    logic [FREQ_W-1:0]      hz_eff;
    logic [DUR_W-1:0]       dur_eff;
    logic [IDX_W-1:0]       len_next;
    logic [IDX_W-2:0]       half_len;
    logic [FADE_W-1:0]      fade_next;
    logic [IDX_W-1:0]       ramp_lo;
    logic [FADE_W-1:0]      env_next;
    logic [FADE_W-1:0]      den_next;
    logic [IDX_W-1:0]       idx_inc;
    logic                   tone_end;
    logic [P_W+32:0]        p_prod;
    logic [1:0]             quad;
    logic [P_W-1:0]         r_full;
    logic [A_W-1:0]         r_pos;
    logic [A_W-1:0]         pos_next;
    logic [PROD_W-1:0]      prod;
    logic [STEP_PROD_W-1:0] step_prod;
    logic [DIV_N_W-1:0]     start_n;
    logic [DIV_N_W-1:0]     sat_lim;
    logic [DIV_D_W:0]       div_trial;
    logic [DIV_D_W-1:0]     rem_step;
    logic [DIV_Q_W-1:0]     nlo_step;
    logic [DIV_Q_W-1:0]     quo_step;
    logic [SAMPLE_W-1:0]    tick_sample;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_take  = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || pcm.ready;

    assign pcm.valid   = out_valid_reg;
    assign pcm.sample  = $signed(out_sample_reg);
    assign pcm.in_tail = out_in_tail_reg;
    assign pcm.last    = out_last_reg;

    assign hz_eff    = (cmd.freq_hz == '0) ? FREQ_W'(DEFAULT_HZ) : cmd.freq_hz;
    assign dur_eff   = (cmd.length_ms == '0) ? DUR_W'(DEFAULT_MS) : cmd.length_ms;
    assign len_next  = {dur_eff, 4'b0000};
    assign half_len  = len_next[IDX_W-1:1];
    assign fade_next = (half_len > (IDX_W - 1)'(RAMP_MAX)) ? FADE_W'(RAMP_MAX)
                                                           : half_len[FADE_W-1:0];

    assign idx_inc  = sample_index_reg + IDX_W'(1);
    assign tone_end = (idx_inc >= frame_total_reg) || (idx_inc == '0);
    assign ramp_lo  = frame_total_reg - IDX_W'(fade_reg);

    always_comb
    begin
        env_next = fade_reg;
        den_next = fade_reg;
        priority if (fade_reg == '0)
        begin
            env_next = FADE_W'(1);
            den_next = FADE_W'(1);
        end
        else if (sample_index_reg < IDX_W'(fade_reg))
        begin
            env_next = sample_index_reg[FADE_W-1:0];
        end
        else if (frame_total_reg >= IDX_W'(fade_reg) && sample_index_reg >= ramp_lo &&
                 sample_index_reg < frame_total_reg)
        begin
            env_next = FADE_W'(frame_total_reg - sample_index_reg - IDX_W'(1));
        end
        else
        begin
            env_next = fade_reg;
        end
    end

    assign p_prod = (P_W + 33)'(phase_acc_reg) * (P_W + 33)'(QUAD_SCALE);

    always_comb
    begin
        priority if (p_reg >= QUAD3)
        begin
            quad   = 2'd3;
            r_full = p_reg - QUAD3;
        end
        else if (p_reg >= QUAD2)
        begin
            quad   = 2'd2;
            r_full = p_reg - QUAD2;
        end
        else if (p_reg >= QUAD1)
        begin
            quad   = 2'd1;
            r_full = p_reg - QUAD1;
        end
        else
        begin
            quad   = 2'd0;
            r_full = p_reg;
        end
        r_pos    = r_full[A_W-1:0];
        pos_next = quad[0] ? (POS_TOP - r_pos) : r_pos;
    end

    assign prod      = PROD_W'(a_reg) * PROD_W'(b_reg);
    assign step_prod = STEP_PROD_W'(hz_reg) * STEP_PROD_W'(STEP_WHOLE);
    assign start_n   = DIV_N_W'(hz_reg) * DIV_N_W'(STEP_REM);
    assign sat_lim   = DIV_N_W'({div_d_reg, {(DIV_Q_W - 1){1'b0}}});

    always_comb
    begin
        rem_step  = rem_reg;
        nlo_step  = nlo_reg;
        quo_step  = quo_reg;
        div_trial = '0;
        for (int j = 0; j < int'(DIV_BITS); j++)
        begin
            div_trial = {rem_step, nlo_step[DIV_Q_W-1]};
            nlo_step  = {nlo_step[DIV_Q_W-2:0], 1'b0};
            if (div_trial >= {1'b0, div_d_reg})
            begin
                rem_step = DIV_D_W'(div_trial - {1'b0, div_d_reg});
                quo_step = {quo_step[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_step = div_trial[DIV_D_W-1:0];
                quo_step = {quo_step[DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            tick_sample = div_sat_reg ? SAT_NEG : (SAMPLE_W'(0) - quo_reg);
        end
        else
        begin
            tick_sample = div_sat_reg ? SAT_POS : quo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            gain_reg         <= GAIN_W'(GAIN_RESET);
            sleeping_reg     <= 1'b0;
            phase_acc_reg    <= '0;
            phase_step_reg   <= '0;
            sample_index_reg <= '0;
            frame_total_reg  <= '0;
            fade_reg         <= '0;
            tail_count_reg   <= '0;
            mode_reg         <= MODE_IDLE;
            op_start_reg     <= 1'b0;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_GAIN_Q12: gain_reg     <= cfg_wdata[GAIN_W-1:0];
                    REG_SLEEPING: sleeping_reg <= cfg_wdata[0];
                endcase
            end
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pcm.valid && pcm.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        if (cmd.action)
                        begin
                            if (!sleeping_reg)
                            begin
                                phase_acc_reg    <= '0;
                                sample_index_reg <= '0;
                                frame_total_reg  <= len_next;
                                fade_reg         <= fade_next;
                                tail_count_reg   <= '0;
                                mode_reg         <= MODE_TONE;
                                op_start_reg     <= 1'b1;
                                state_reg        <= S_STEP;
                            end
                        end
                        else if (mode_reg == MODE_TONE)
                        begin
                            phase_acc_reg    <= phase_acc_reg + phase_step_reg;
                            sample_index_reg <= idx_inc;
                            if (tone_end)
                            begin
                                if (TAIL_SAMPLES != 0)
                                begin
                                    tail_count_reg <= TAIL_LOAD;
                                    mode_reg       <= MODE_TAIL;
                                end
                                else
                                begin
                                    mode_reg <= MODE_IDLE;
                                end
                            end
                            op_start_reg <= 1'b0;
                            if (!sleeping_reg)
                            begin
                                state_reg <= S_ADDR;
                            end
                        end
                        else if (mode_reg == MODE_TAIL)
                        begin
                            if (tail_count_reg != '0)
                            begin
                                tail_count_reg <= tail_count_reg - TAIL_W'(1);
                            end
                            if (tail_count_reg <= TAIL_W'(1))
                            begin
                                mode_reg <= MODE_IDLE;
                            end
                            if (!sleeping_reg)
                            begin
                                state_reg <= S_EMIT;
                            end
                        end
                    end
                end
                S_ADDR:     state_reg <= S_ROM;
                S_ROM:      state_reg <= S_MUL1;
                S_MUL1:     state_reg <= S_MUL2;
                S_MUL2:     state_reg <= S_DIV_LOAD;
                S_STEP:     state_reg <= S_DIV_LOAD;
                S_DIV_LOAD:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (op_start_reg)
                    begin
                        phase_step_reg <= step_hi_reg + PHASE_W'(quo_reg);
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    hz_reg  <= hz_eff;
                    p_reg   <= p_prod[32 +: P_W];
                    env_reg <= env_next;
                    den_reg <= den_next;
                    if (mode_reg == MODE_TAIL)
                    begin
                        res_sample_reg  <= '0;
                        res_in_tail_reg <= 1'b1;
                        res_last_reg    <= (tail_count_reg <= TAIL_W'(1));
                    end
                    else
                    begin
                        res_sample_reg  <= '0;
                        res_in_tail_reg <= 1'b0;
                        res_last_reg    <= tone_end && (TAIL_SAMPLES == 0);
                    end
                end
            end
            S_ADDR:
            begin
                pos_reg <= pos_next;
                neg_reg <= quad[1];
            end
            S_MUL1:
            begin
                a_reg <= MAG_GAIN_W'(rom_q_reg) * MAG_GAIN_W'(gain_reg);
                b_reg <= ENV_AMP_W'(env_reg) * ENV_AMP_W'(AMP_SCALE);
            end
            S_MUL2:
            begin
                div_n_reg <= prod[MUL_SHIFT +: DIV_N_W];
                div_d_reg <= den_reg;
            end
            S_STEP:
            begin
                step_hi_reg <= step_prod[PHASE_W-1:0];
                div_n_reg   <= start_n;
                div_d_reg   <= DIV_D_W'(STEP_DIV);
            end
            S_DIV_LOAD:
            begin
                div_sat_reg <= (div_n_reg >= sat_lim);
                rem_reg     <= div_n_reg[DIV_Q_W +: DIV_D_W];
                nlo_reg     <= div_n_reg[DIV_Q_W-1:0];
                quo_reg     <= '0;
            end
            S_DIV:
            begin
                rem_reg <= rem_step;
                nlo_reg <= nlo_step;
                quo_reg <= quo_step;
            end
            S_FIN:
            begin
                res_sample_reg <= tick_sample;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_sample_reg  <= res_sample_reg;
                    out_in_tail_reg <= res_in_tail_reg;
                    out_last_reg    <= res_last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    `FTBG_ASSERT(a_tail_count_live, (mode_reg == MODE_TAIL) |-> (tail_count_reg != '0), "Tail mode with an empty tail count.")
    `FTBG_ASSERT(a_fade_bounded, (mode_reg == MODE_TONE) |-> (fade_reg != '0 && fade_reg <= FADE_W'(RAMP_MAX)), "Fade length out of range during a tone.")
    `FTBG_ASSERT(a_div_rem_below, (state_reg == S_DIV && !div_sat_reg) |-> (rem_reg < div_d_reg), "Divider remainder reached the divisor.")
    `FTBG_ASSERT(a_quo_range, (state_reg == S_FIN && !div_sat_reg) |-> !quo_reg[DIV_Q_W-1], "Unsaturated quotient exceeds the sample range.")
    `FTBG_ASSERT(a_out_from_emit, $rose(out_valid_reg) |-> $past(state_reg == S_EMIT), "Output item loaded outside the emit state.")
    `FTBG_ASSERT_NEVER(a_step_needs_tone, state_reg == S_FIN && op_start_reg && mode_reg != MODE_TONE, "Phase step finished without a running tone.")

endmodule
